// ===== hdl/bm3_pkg.sv =====
`default_nettype none

package bm3_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SHAPE = 2'd3;

  // Register reset values
  localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd10;
  localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd10;

  // Mode and element codes
  localparam logic MODE_DILATE  = 1'b0;
  localparam logic MODE_ERODE   = 1'b1;
  localparam logic SHAPE_CROSS  = 1'b0;
  localparam logic SHAPE_SQUARE = 1'b1;

  // Window bits covered by the cross: centre plus 4-neighbours
  localparam logic [8:0] ELEM_CROSS  = 9'h0BA;
  localparam logic [8:0] ELEM_SQUARE = 9'h1FF;

  // Which neighbours of the output position lie inside the image
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } border_t;

  // Control that follows one item from the address stage to the window stage
  typedef struct packed {
    logic    pixel;   // pixel item: writes back to the line stores
    logic    bottom;  // new bottom-row bit
    logic    emit;    // item gives a result
    logic    eor;
    logic    eof;
    border_t border;
  } s1_ctl_t;

  // Shift one column into the window; bit r*3+c, column 2 newest
  function automatic logic [8:0] win_shift(input logic [8:0] win, input logic top,
                                           input logic mid, input logic bot);
    win_shift = {bot, win[8:7], mid, win[5:4], top, win[2:1]};
  endfunction

  // OR or AND over the element, with outside positions as zero
  function automatic logic morph_eval(input logic [8:0] win, input border_t b,
                                      input logic mode, input logic shape);
    logic [8:0] elem;
    logic [8:0] in_img;
    logic [8:0] vals;
    elem   = (shape == SHAPE_SQUARE) ? ELEM_SQUARE : ELEM_CROSS;
    in_img = 9'h1FF;
    if (!b.top)   in_img = in_img & 9'h1F8;
    if (!b.bot)   in_img = in_img & 9'h03F;
    if (!b.left)  in_img = in_img & 9'h1B6;
    if (!b.right) in_img = in_img & 9'h0DB;
    vals = win & in_img;
    if (mode == MODE_ERODE) begin
      morph_eval = &(vals | ~elem);
    end else begin
      morph_eval = |(vals & elem);
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bm3_if.sv =====
`default_nettype none

// Input pixel channel
interface bm3_in_if;
  logic valid;
  logic ready;
  logic pixel_in;
  logic flush;

  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

// Result pixel channel
interface bm3_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic end_of_row;
  logic end_of_frame;

  modport source (output valid, output pixel_out, output end_of_row,
                  output end_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input end_of_row,
                  input end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== hdl/bm3_ram.sv =====
`default_nettype none

module bm3_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/binary_morphology_3x3_unit.sv =====
// 3x3 binary dilation / erosion on a raster pixel stream.
//
// in_ch carries one beat per pixel (pixel_in) in raster order, or a flush beat
// (flush = 1) that drains the tail of a finished frame. out_ch carries one
// result beat (pixel_out, end_of_row, end_of_frame) per output position.
// cfg_we / cfg_index / cfg_data write image_width, image_height, mode and
// element_shape; write them only while the block is idle. A width or height
// write restarts the stream.
//
// Throughput is one beat per cycle in both directions while out_ch does not
// stall. The result of an output position leaves image_width + 1 input beats
// after its pixel; the beat that releases it reaches out_ch via the window
// and output registers after its line store read. The line stores are a
// single 2-bit RAM read and written once per cycle, with forwarding when a
// read hits the column being written back.
//
// Reset clears positions, counts, the window and the output register; the
// line stores are not cleared and need no clearing pass. When out_ch stalls,
// the result holds in the output register and in_ch.ready drops only once
// the window stage also holds a beat.
`default_nettype none

module binary_morphology_3x3_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bm3_in_if.sink                              in_ch,
  bm3_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [bm3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bm3_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = $clog2(MAX_WIDTH + 3);

  // Configuration registers
  logic [bm3_pkg::CFG_WIDTH_W-1:0]  width_r;
  logic [bm3_pkg::CFG_HEIGHT_W-1:0] height_r;
  logic                             mode_r;
  logic                             shape_r;
  logic                             restart;

  // Effective geometry
  logic [31:0]   w_full;
  logic [31:0]   h_full;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  // Stream position state
  logic [CW-1:0] in_col_r,  in_col_nxt;
  logic [RW-1:0] in_row_r,  in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic [PW-1:0] pend_r,    pend_nxt;
  logic          drain_r,   drain_nxt;

  // Address stage
  logic             acc;
  logic             take;
  logic [CW-1:0]    rd_addr;
  bm3_pkg::s1_ctl_t s0_ctl;
  logic             fwd_hit;

  // Window stage
  logic             s1_valid_r;
  bm3_pkg::s1_ctl_t s1_ctl_r;
  logic [CW-1:0]    s1_addr_r;
  logic             fwd_r;
  logic [1:0]       fwd_data_r;
  logic [1:0]       ram_rd;
  logic             up_eff;
  logic             md_eff;
  logic [8:0]       window_r;
  logic [8:0]       win_nxt;
  logic             s1_go;
  logic             in_ready;

  // Output register
  logic out_valid_r;
  logic pix_out_r;
  logic eor_out_r;
  logic eof_out_r;
  logic out_free;

  assign restart = cfg_we && (cfg_index == bm3_pkg::REG_IMAGE_WIDTH ||
                              cfg_index == bm3_pkg::REG_IMAGE_HEIGHT);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bm3_pkg::RST_IMAGE_WIDTH;
      height_r <= bm3_pkg::RST_IMAGE_HEIGHT;
      mode_r   <= bm3_pkg::MODE_DILATE;
      shape_r  <= bm3_pkg::SHAPE_CROSS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bm3_pkg::REG_IMAGE_WIDTH:   width_r  <= cfg_data[bm3_pkg::CFG_WIDTH_W-1:0];
        bm3_pkg::REG_IMAGE_HEIGHT:  height_r <= cfg_data[bm3_pkg::CFG_HEIGHT_W-1:0];
        bm3_pkg::REG_MODE:          mode_r   <= cfg_data[0];
        bm3_pkg::REG_ELEMENT_SHAPE: shape_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp geometry to 1..maximum
  always_comb begin
    w_full = 32'(width_r);
    if (w_full == 32'd0) w_full = 32'd1;
    if (w_full > 32'(MAX_WIDTH)) w_full = 32'(MAX_WIDTH);
    h_full = 32'(height_r);
    if (h_full == 32'd0) h_full = 32'd1;
    if (h_full > 32'(MAX_HEIGHT)) h_full = 32'(MAX_HEIGHT);
    w_eff = WW'(w_full);
    h_eff = HW'(h_full);
  end

  // Handshake
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_go;
  assign acc      = in_ch.valid && in_ready;

  // Address stage: positions, counts, result flags and read address
  always_comb begin
    logic [CW-1:0] oc;
    logic [RW-1:0] orow;
    logic [PW-1:0] pb;
    logic [31:0]   fcol;
    logic          em;
    logic          eor;
    logic          eof;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pend_nxt    = pend_r;
    drain_nxt   = drain_r;
    take        = 1'b0;
    rd_addr     = in_col_r;
    s0_ctl      = '0;

    oc   = out_col_r;
    orow = out_row_r;
    pb   = pend_r;
    em   = 1'b0;
    fcol = 32'd0;

    if (acc) begin
      if (in_ch.flush) begin
        // Drain only at frame start with results pending
        if (pend_r != '0 && in_col_r == '0 && in_row_r == '0) begin
          take     = 1'b1;
          em       = 1'b1;
          pend_nxt = pend_r - PW'(1);
          drain_nxt = (pend_nxt != '0);
          fcol = 32'(out_col_r) + 32'd1;
          if (fcol >= 32'(w_eff)) fcol = 32'd0;
          rd_addr = CW'(fcol);
        end
      end else begin
        // A pixel drops what is left of a partial drain
        if (drain_r) begin
          oc   = '0;
          orow = '0;
          pb   = '0;
        end
        drain_nxt   = 1'b0;
        out_col_nxt = oc;
        out_row_nxt = orow;
        take        = 1'b1;
        rd_addr     = in_col_r;
        if (32'(in_col_r) + 32'd1 >= 32'(w_eff)) begin
          in_col_nxt = '0;
          in_row_nxt = (32'(in_row_r) + 32'd1 >= 32'(h_eff)) ? '0 : in_row_r + RW'(1);
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
        em       = (32'(pb) == 32'(w_eff) + 32'd1);
        pend_nxt = em ? pb : pb + PW'(1);
      end
    end

    eor = (32'(oc) + 32'd1 >= 32'(w_eff));
    eof = eor && (32'(orow) + 32'd1 >= 32'(h_eff));

    // Advance the output position
    if (em) begin
      if (eor) begin
        out_col_nxt = '0;
        out_row_nxt = eof ? '0 : orow + RW'(1);
      end else begin
        out_col_nxt = oc + CW'(1);
      end
    end

    s0_ctl.pixel        = !in_ch.flush;
    s0_ctl.bottom       = !in_ch.flush && in_ch.pixel_in;
    s0_ctl.emit         = em;
    s0_ctl.eor          = eor;
    s0_ctl.eof          = eof;
    s0_ctl.border.top   = (orow != '0);
    s0_ctl.border.bot   = (32'(orow) + 32'd1 < 32'(h_eff));
    s0_ctl.border.left  = (oc != '0);
    s0_ctl.border.right = (32'(oc) + 32'd1 < 32'(w_eff));
  end

  // Forward when the read hits the column written back this cycle
  assign fwd_hit = s1_go && s1_ctl_r.pixel && (s1_addr_r == rd_addr);

  // Position and count registers
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
      drain_r   <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
      drain_r   <= drain_nxt;
    end
  end

  // Window stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc && take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Window stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctl_r   <= s0_ctl;
      s1_addr_r  <= rd_addr;
      fwd_r      <= fwd_hit;
      fwd_data_r <= {md_eff, s1_ctl_r.bottom};
    end
  end

  // Line stores: bit 1 upper row, bit 0 middle row
  bm3_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (s1_go && s1_ctl_r.pixel),
    .wr_addr (s1_addr_r),
    .wr_data ({md_eff, s1_ctl_r.bottom}),
    .rd_en   (acc && take),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  assign up_eff  = fwd_r ? fwd_data_r[1] : ram_rd[1];
  assign md_eff  = fwd_r ? fwd_data_r[0] : ram_rd[0];
  assign win_nxt = bm3_pkg::win_shift(window_r, up_eff, md_eff, s1_ctl_r.bottom);

  // Window register
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      window_r <= '0;
    end else if (s1_go) begin
      window_r <= win_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_ctl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_ctl_r.emit) begin
      pix_out_r <= bm3_pkg::morph_eval(win_nxt, s1_ctl_r.border, mode_r, shape_r);
      eor_out_r <= s1_ctl_r.eor;
      eof_out_r <= s1_ctl_r.eof;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_out    = pix_out_r;
  assign out_ch.end_of_row   = eor_out_r;
  assign out_ch.end_of_frame = eof_out_r;

endmodule

`default_nettype wire

// ===== hdl/bm3_checker.sv =====
`default_nettype none

module bm3_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic pixel_out,
  input wire logic end_of_row,
  input wire logic end_of_frame
);

  // Output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result beat shown right after reset");

  // Frame end only on a row end
  a_eof_on_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_of_frame |-> end_of_row)
    else $error("end_of_frame without end_of_row");

  // A free receiver never throttles the input
  a_full_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) &&
      $stable(end_of_row) && $stable(end_of_frame))
    else $error("stalled result beat changed");

endmodule

bind binary_morphology_3x3_unit bm3_checker u_bm3_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pixel_out    (out_ch.pixel_out),
  .end_of_row   (out_ch.end_of_row),
  .end_of_frame (out_ch.end_of_frame)
);

`default_nettype wire

// ===== tb/bm3_window_check.sv =====
`timescale 1ns / 100ps

module bm3_window_check #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bm3_in_if                              in_mon,
  bm3_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [bm3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bm3_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             results_owed
);

  typedef struct packed {
    logic pixel;
    logic eor;
    logic eof;
  } morph_beat_t;

  // Predicted result beats, oldest first
  morph_beat_t expected_pixels[$];

  // Shadow of the block: line stores, window, raster positions
  logic        line_upper  [MAX_WIDTH];
  logic        line_middle [MAX_WIDTH];
  logic [8:0]  window;
  int unsigned in_col, in_row, out_col, out_row;
  int unsigned held_pixels;
  bit          draining;

  // Shadow of the registers
  logic [bm3_pkg::CFG_WIDTH_W-1:0]  width_reg;
  logic [bm3_pkg::CFG_HEIGHT_W-1:0] height_reg;
  logic                             mode_reg;
  logic                             shape_reg;

  function automatic void restart_stream();
    window      = '0;
    in_col      = 0;
    in_row      = 0;
    out_col     = 0;
    out_row     = 0;
    held_pixels = 0;
    draining    = 1'b0;
  endfunction

  // Shift one column into the window; bit r*3+c, column 2 is the newest
  function automatic void slide_window(input logic top_b, input logic mid_b,
                                       input logic bot_b);
    logic [2:0] fresh;
    logic [2:0] grp;
    int         r;
    fresh = {bot_b, mid_b, top_b};
    for (r = 0; r < 3; r++) begin
      grp = window[3*r +: 3];
      window[3*r +: 3] = {fresh[r], grp[2:1]};
    end
  endfunction

  // Evaluate the element at the output position and advance it
  function automatic void release_pixel(input int unsigned w, input int unsigned h);
    morph_beat_t beat;
    logic        acc;
    logic        bit_v;
    bit          in_img;
    int          r;
    int          c;
    acc = (mode_reg == bm3_pkg::MODE_ERODE);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (shape_reg == bm3_pkg::SHAPE_SQUARE || r == 1 || c == 1) begin
          in_img = !((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h) ||
                     (c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w));
          bit_v = in_img ? window[r*3 + c] : 1'b0;
          acc = (mode_reg == bm3_pkg::MODE_ERODE) ? (acc & bit_v) : (acc | bit_v);
        end
      end
    end
    beat.pixel = acc;
    beat.eor   = (out_col + 1 >= w);
    beat.eof   = beat.eor && (out_row + 1 >= h);
    expected_pixels.push_back(beat);
    if (beat.eor) begin
      out_col = 0;
      out_row = beat.eof ? 0 : out_row + 1;
    end else begin
      out_col++;
    end
    if (held_pixels > 0) held_pixels--;
  endfunction

  function automatic void check_field(input string name, input logic want_v,
                                      input logic got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %b, got %b", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    morph_beat_t want;
    int unsigned w;
    int unsigned h;
    int unsigned col;
    logic        top_b;
    logic        mid_b;
    int          i;
    if (!rst_n) begin
      for (i = 0; i < MAX_WIDTH; i++) begin
        line_upper[i]  = 1'b0;
        line_middle[i] = 1'b0;
      end
      width_reg  = bm3_pkg::RST_IMAGE_WIDTH;
      height_reg = bm3_pkg::RST_IMAGE_HEIGHT;
      mode_reg   = bm3_pkg::MODE_DILATE;
      shape_reg  = bm3_pkg::SHAPE_CROSS;
      restart_stream();
      expected_pixels.delete();
      mismatch_count = 0;
    end else begin
      // Compare each result beat with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with none expected: pixel_out=%b end_of_row=%b end_of_frame=%b",
                   $time, out_mon.pixel_out, out_mon.end_of_row, out_mon.end_of_frame);
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_out", want.pixel, out_mon.pixel_out);
          check_field("end_of_row", want.eor, out_mon.end_of_row);
          check_field("end_of_frame", want.eof, out_mon.end_of_frame);
        end
      end

      // Track register writes; a geometry write restarts the stream
      if (cfg_we) begin
        case (cfg_index)
          bm3_pkg::REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[bm3_pkg::CFG_WIDTH_W-1:0];
            restart_stream();
          end
          bm3_pkg::REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[bm3_pkg::CFG_HEIGHT_W-1:0];
            restart_stream();
          end
          bm3_pkg::REG_MODE:          mode_reg = cfg_data[0];
          bm3_pkg::REG_ELEMENT_SHAPE: shape_reg = cfg_data[0];
          default: ;
        endcase
      end

      // Predict the effect of each accepted input beat
      if (in_mon.valid && in_mon.ready) begin
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        if (in_mon.flush) begin
          // Drain only at the start of a frame with outputs still owed
          if (held_pixels != 0 && in_col == 0 && in_row == 0) begin
            draining = 1'b1;
            col = (out_col + 1 >= w) ? 0 : out_col + 1;
            slide_window(line_upper[col], line_middle[col], 1'b0);
            release_pixel(w, h);
            if (held_pixels == 0) draining = 1'b0;
          end
        end else begin
          // A pixel during a partial drain drops the rest of the old frame
          if (draining) begin
            held_pixels = 0;
            out_col     = 0;
            out_row     = 0;
            draining    = 1'b0;
          end
          top_b = line_upper[in_col];
          mid_b = line_middle[in_col];
          slide_window(top_b, mid_b, in_mon.pixel_in);
          line_upper[in_col]  = mid_b;
          line_middle[in_col] = in_mon.pixel_in;
          if (in_col + 1 >= w) begin
            in_col = 0;
            in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
          end else begin
            in_col++;
          end
          held_pixels++;
          if (held_pixels > w + 1) release_pixel(w, h);
        end
      end
    end
    results_owed <= expected_pixels.size();
  end

endmodule

// ===== tb/tb_binary_morphology_3x3_unit.sv =====
`timescale 1ns / 100ps

module tb_binary_morphology_3x3_unit;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RANDOM_BEATS  = 760;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_STALL    = 300;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef enum int {
    FRAME_DRAINED,
    FRAME_BACK_TO_BACK,
    FRAME_PARTIAL_DRAIN,
    FRAME_TRUNCATED
  } frame_end_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [bm3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bm3_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           sink_ready = 1'b0;

  int          mismatch_count;
  int          results_owed;
  int          beats_sent = 0;
  int          src_idle_pct = 35;
  int          sink_idle_pct = 60;
  int          cycle_count = 0;
  bit          stall_request = 1'b0;
  bit          stall_done = 1'b0;
  int          stall_left = 0;

  bm3_in_if  in_ch ();
  bm3_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  binary_morphology_3x3_unit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bm3_window_check #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) window_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (stall_left != 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_request && !stall_done) begin
      sink_ready <= 1'b0;
      stall_left <= LONG_STALL;
      stall_done <= 1'b1;
    end else begin
      sink_ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  // Offer one beat, with random idle cycles ahead of it
  task automatic send_beat(input logic pix, input logic fl);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.pixel_in <= pix;
    in_ch.flush    <= fl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Hold the input until every predicted result is out and the pipe is empty
  task automatic drain_to_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_unit(input logic [bm3_pkg::CFG_DATA_W-1:0] w_data,
                              input logic [bm3_pkg::CFG_DATA_W-1:0] h_data,
                              input logic m, input logic s);
    logic [bm3_pkg::CFG_DATA_W-1:0] noise;
    drain_to_idle();
    noise     = bm3_pkg::CFG_DATA_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= bm3_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= w_data;
    @(posedge clk);
    cfg_index <= bm3_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= h_data;
    @(posedge clk);
    cfg_index <= bm3_pkg::REG_MODE;
    cfg_data  <= {noise[bm3_pkg::CFG_DATA_W-1:1], m};
    @(posedge clk);
    noise     = bm3_pkg::CFG_DATA_W'($urandom);
    cfg_index <= bm3_pkg::REG_ELEMENT_SHAPE;
    cfg_data  <= {noise[bm3_pkg::CFG_DATA_W-1:1], s};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One raster frame with random content, a few stray flushes, and a chosen ending
  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input frame_end_t ending);
    int unsigned dens;
    int unsigned cut;
    case ($urandom_range(2, 0))
      0:       dens = 10;
      1:       dens = 50;
      default: dens = 90;
    endcase
    cut = (ending == FRAME_TRUNCATED) ? $urandom_range(w * h, 1) : w * h;
    repeat (cut) begin
      if ($urandom_range(99, 0) < 4) send_beat(1'($urandom_range(1, 0)), 1'b1);
      send_beat($urandom_range(99, 0) < dens, 1'b0);
    end
    case (ending)
      FRAME_DRAINED:       repeat (w + 1) send_beat(1'($urandom_range(1, 0)), 1'b1);
      FRAME_PARTIAL_DRAIN: repeat ($urandom_range(w, 1))
                             send_beat(1'($urandom_range(1, 0)), 1'b1);
      FRAME_TRUNCATED:     repeat ($urandom_range(3, 1))
                             send_beat(1'($urandom_range(1, 0)), 1'b1);
      default: ;
    endcase
  endtask

  // New geometry and operation, then one to three frames
  task automatic random_phase();
    int unsigned                    w;
    int unsigned                    h;
    int unsigned                    frames;
    int unsigned                    f;
    int unsigned                    pick;
    logic [bm3_pkg::CFG_DATA_W-1:0] w_data;
    logic [bm3_pkg::CFG_DATA_W-1:0] h_data;
    frame_end_t                     ending;
    if ($urandom_range(19, 0) == 0) begin
      w = $urandom_range(40, 9);
      h = $urandom_range(12, 2);
    end else begin
      w = $urandom_range(8, 1);
      h = $urandom_range(6, 1);
    end
    // Bits above the width register are don't-care; zero size counts as one
    w_data = bm3_pkg::CFG_DATA_W'(w);
    w_data[bm3_pkg::CFG_DATA_W-1:bm3_pkg::CFG_WIDTH_W] = 2'($urandom_range(3, 0));
    if (w == 1 && $urandom_range(1, 0) == 1) w_data[bm3_pkg::CFG_WIDTH_W-1:0] = '0;
    h_data = bm3_pkg::CFG_DATA_W'(h);
    if (h == 1 && $urandom_range(1, 0) == 1) h_data = '0;
    program_unit(w_data, h_data, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
    frames = $urandom_range(3, 1);
    for (f = 1; f <= frames; f++) begin
      pick = $urandom_range(99, 0);
      if (f == frames && pick < 80)  ending = FRAME_DRAINED;
      else if (pick < 50)            ending = FRAME_DRAINED;
      else if (pick < 70)            ending = FRAME_BACK_TO_BACK;
      else if (pick < 85)            ending = FRAME_PARTIAL_DRAIN;
      else                           ending = FRAME_TRUNCATED;
      send_frame(w, h, ending);
    end
  endtask

  initial begin
    int base;
    int progress;
    int i;
    in_ch.valid    = 1'b0;
    in_ch.pixel_in = 1'b0;
    in_ch.flush    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Flush with nothing owed, at the reset geometry
    send_beat(1'b1, 1'b1);

    // Dilation by the cross of a single dot, with a stray flush mid-frame
    program_unit(13'd3, 13'd3, bm3_pkg::MODE_DILATE, bm3_pkg::SHAPE_CROSS);
    for (i = 0; i < 9; i++) begin
      if (i == 5) send_beat(1'b0, 1'b1);
      send_beat(i == 4, 1'b0);
    end
    repeat (4) send_beat(1'b1, 1'b1);
    send_beat(1'b0, 1'b1);

    // Erosion of a full frame at the border, cut short by a new pixel mid-drain
    program_unit(13'd3, 13'd3, bm3_pkg::MODE_ERODE, bm3_pkg::SHAPE_SQUARE);
    repeat (9) send_beat(1'b1, 1'b0);
    repeat (2) send_beat(1'b0, 1'b1);
    send_beat(1'b1, 1'b0);

    // Geometry extremes, clamped values among them
    program_unit(13'd0, 13'd5, bm3_pkg::MODE_DILATE, bm3_pkg::SHAPE_CROSS);
    send_frame(1, 5, FRAME_DRAINED);
    program_unit(13'd2, 13'd4096, bm3_pkg::MODE_ERODE, bm3_pkg::SHAPE_SQUARE);
    repeat (9) send_beat($urandom_range(99, 0) < 90, 1'b0);
    program_unit(13'd1, 13'h1FFF, bm3_pkg::MODE_DILATE, bm3_pkg::SHAPE_SQUARE);
    repeat (12) send_beat(1'($urandom_range(1, 0)), 1'b0);
    program_unit(13'd4, 13'd0, bm3_pkg::MODE_ERODE, bm3_pkg::SHAPE_CROSS);
    send_frame(4, 1, FRAME_DRAINED);

    // Random phases; swap the idle rates, then stream flat out
    base = beats_sent;
    while (beats_sent - base < RANDOM_BEATS) begin
      progress = beats_sent - base;
      if (progress >= 2 * RANDOM_BEATS / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        if (!stall_request) begin
          // Long receiver hold-off while the sender keeps offering
          program_unit(13'd6, 13'd8, bm3_pkg::MODE_DILATE, bm3_pkg::SHAPE_SQUARE);
          stall_request = 1'b1;
          send_frame(6, 8, FRAME_DRAINED);
          send_frame(6, 8, FRAME_DRAINED);
        end else begin
          random_phase();
        end
      end else begin
        if (progress >= RANDOM_BEATS / 3) begin
          src_idle_pct  = 60;
          sink_idle_pct = 35;
        end
        random_phase();
      end
    end

    drain_to_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bm3_pkg.sv
hdl/bm3_if.sv
hdl/bm3_ram.sv
hdl/binary_morphology_3x3_unit.sv
hdl/bm3_checker.sv
tb/bm3_window_check.sv
tb/tb_binary_morphology_3x3_unit.sv
